FILE: rtl/core/drq_pkg.sv
// ----------------------------------------------------------------------------
// drq_pkg
// Shared constants and types for the dense rank query block.
// ----------------------------------------------------------------------------
package drq_pkg;

  localparam int unsigned DefTableDepth = 256;
  localparam int unsigned DefScoreBits  = 32;

  localparam int unsigned InScoreW = 32;
  localparam int unsigned RankW    = 9;
  localparam logic [RankW-1:0] RankMax = 9'd511;

  // opcodes; code 3 is unused and behaves as a no-op
  localparam logic [1:0] OpLoad  = 2'd0;
  localparam logic [1:0] OpQuery = 2'd1;
  localparam logic [1:0] OpClear = 2'd2;

  // token control that moves down the cell row
  typedef struct packed {
    logic active;
    logic found;
  } drq_ctl_t;

endpackage

FILE: rtl/core/drq_cell.sv
// ----------------------------------------------------------------------------
// drq_cell
// One table entry. Compares the broadcast key against its stored score and
// hands the running greater-count and match flag to the next cell.
// ----------------------------------------------------------------------------
module drq_cell #(
  parameter int unsigned SCORE_BITS = drq_pkg::DefScoreBits,
  parameter int unsigned CW         = 9,
  parameter int unsigned IDX        = 0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [SCORE_BITS-1:0] key_i,
  input  logic [CW-1:0]         count_i,
  input  logic                  wr_en_i,
  input  drq_pkg::drq_ctl_t     ctl_i,
  input  logic [CW-1:0]         gt_i,
  output drq_pkg::drq_ctl_t     ctl_o,
  output logic [CW-1:0]         gt_o
);
  import drq_pkg::*;

  logic [SCORE_BITS-1:0] score_q;
  drq_ctl_t              ctl_q, ctl_d;
  logic [CW-1:0]         gt_q, gt_d;
  logic                  valid;

  // entry holds data only below the fill count
  assign valid = count_i > CW'(IDX);

  always_comb begin
    ctl_d        = ctl_i;
    gt_d         = gt_i;
    if (valid && ctl_i.active) begin
      if (score_q == key_i) ctl_d.found = 1'b1;
      if (score_q > key_i)  gt_d = gt_i + CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i && (count_i == CW'(IDX))) begin
      score_q <= key_i;
    end
    gt_q <= gt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_d;
    end
  end

  assign ctl_o = ctl_q;
  assign gt_o  = gt_q;

endmodule

FILE: rtl/core/dense_rank_query_top.sv
// ----------------------------------------------------------------------------
// dense_rank_query_top
// Table of distinct scores answering dense-rank queries.
// ----------------------------------------------------------------------------
// Usage:
//   Drive opcode_i and score_value_i with start_i high; the word is taken at
//   the rising edge where start_i is high and busy_o is low. busy_o stays high
//   until the result is issued.
//   Each word gives one result: result_valid_o pulses for one cycle with
//   rank_value_o and status_o. The receiver cannot stall; it must take it.
//   Load inserts a new score (duplicates ignored, status_o=1 if full),
//   query returns 1 + count of stored scores above the key, clear empties.
//   The search token walks the cell row one cell per cycle, from the launch
//   register through each cell's register; the result is registered once
//   the token leaves the last cell. No new word is taken while busy_o is high.
//   Reset empties the table (fill count to zero); no clearing pass is needed.
// ----------------------------------------------------------------------------
module dense_rank_query_top #(
  parameter int unsigned TABLE_DEPTH = drq_pkg::DefTableDepth,
  parameter int unsigned SCORE_BITS  = drq_pkg::DefScoreBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [1:0]                    opcode_i,
  input  logic [drq_pkg::InScoreW-1:0]  score_value_i,
  output logic                          result_valid_o,
  output logic [drq_pkg::RankW-1:0]     rank_value_o,
  output logic                          status_o
);
  import drq_pkg::*;

  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  logic                  busy_q, launch_q;
  logic [1:0]            op_q;
  logic [SCORE_BITS-1:0] key_q;
  logic [CW-1:0]         count_q;
  logic                  res_valid_q, status_q;
  logic [RankW-1:0]      rank_q;

  drq_ctl_t      ctl_chain [TABLE_DEPTH+1];
  logic [CW-1:0] gt_chain  [TABLE_DEPTH+1];

  logic          accept, done, not_full, wr_en;
  logic [CW:0]   rank_full;
  logic [RankW-1:0] rank_sat;

  assign accept   = start_i && !busy_q;
  assign done     = ctl_chain[TABLE_DEPTH].active;
  assign not_full = count_q < CW'(TABLE_DEPTH);
  assign wr_en    = done && (op_q == OpLoad) && !ctl_chain[TABLE_DEPTH].found && not_full;

  assign ctl_chain[0] = '{active: launch_q, found: 1'b0};
  assign gt_chain[0]  = '0;

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    drq_cell #(
      .SCORE_BITS(SCORE_BITS),
      .CW        (CW),
      .IDX       (g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .key_i  (key_q),
      .count_i(count_q),
      .wr_en_i(wr_en),
      .ctl_i  (ctl_chain[g]),
      .gt_i   (gt_chain[g]),
      .ctl_o  (ctl_chain[g+1]),
      .gt_o   (gt_chain[g+1])
    );
  end

  // rank = greater count + 1, saturated to the field
  always_comb begin
    rank_full = {1'b0, gt_chain[TABLE_DEPTH]} + (CW+1)'(1);
    if (32'(rank_full) > 32'(RankMax)) rank_sat = RankMax;
    else                               rank_sat = RankW'(rank_full);
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= opcode_i;
      key_q <= SCORE_BITS'(score_value_i);
    end
    if (done) begin
      rank_q   <= (op_q == OpQuery) ? rank_sat : '0;
      status_q <= (op_q == OpLoad) && !ctl_chain[TABLE_DEPTH].found && !not_full;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      launch_q    <= 1'b0;
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      launch_q    <= accept;
      res_valid_q <= done;
      if (accept)    busy_q <= 1'b1;
      else if (done) busy_q <= 1'b0;
      if (done && (op_q == OpClear)) count_q <= '0;
      else if (wr_en)                count_q <= count_q + CW'(1);
    end
  end

  assign busy_o         = busy_q;
  assign result_valid_o = res_valid_q;
  assign rank_value_o   = rank_q;
  assign status_o       = status_q;

endmodule

FILE: rtl/core/drq_checker.sv
// ----------------------------------------------------------------------------
// drq_checker
// Port-level checks on the command handshake, result strobe and dropped-load rank.
// ----------------------------------------------------------------------------
module drq_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start_i,
  input logic                         busy_o,
  input logic                         result_valid_o,
  input logic [drq_pkg::RankW-1:0]    rank_value_o,
  input logic                         status_o
);
  import drq_pkg::*;

  // an accepted word keeps the block busy
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("busy_o low after accepted word");

  // result only once the word is finished
  a_result_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy_o)
    else $error("result while busy");

  // one-cycle strobe
  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");

  // a dropped load carries no rank
  a_drop_no_rank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && status_o) |-> (rank_value_o == '0))
    else $error("dropped load with nonzero rank");

endmodule

bind dense_rank_query_top drq_checker u_drq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start_i       (start_i),
  .busy_o        (busy_o),
  .result_valid_o(result_valid_o),
  .rank_value_o  (rank_value_o),
  .status_o      (status_o)
);
